// File: rtl/pew_pkg.sv
// Shared constants and types of the Prewitt edge threshold block.
`default_nettype none

package pew_pkg;

	localparam int MAX_WIDTH = 512;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 8;
	localparam int WID_W     = 10;
	localparam int HGT_W     = 12;
	localparam int THR_W     = 11;
	localparam int MAG_W     = 11;
	localparam int SUM_W     = PIX_W + 2;
	localparam int CNT_W     = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(512);
	localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(512);
	localparam logic [THR_W-1:0] THRESH_RST = THR_W'(128);
	localparam logic [CNT_W-1:0] MIN_DIM    = CNT_W'(3);
	localparam logic [CNT_W-1:0] MAX_DIM    = CNT_W'(MAX_WIDTH);

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] tl;
		logic [PIX_W-1:0] tc;
		logic [PIX_W-1:0] tr;
		logic [PIX_W-1:0] ml;
		logic [PIX_W-1:0] mr;
		logic [PIX_W-1:0] bl;
		logic [PIX_W-1:0] bc;
		logic [PIX_W-1:0] br;
	} win_t;

endpackage

`default_nettype wire

// File: rtl/pew_if.sv
// Valid/ready stream interfaces for pixel beats and result beats.
`default_nettype none

interface pew_pix_if;
	logic                       valid;
	logic                       ready;
	logic [pew_pkg::PIX_W-1:0]  pixel;
	logic                       frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface pew_res_if;
	logic                       valid;
	logic                       ready;
	logic                       edge_flag;
	logic [pew_pkg::MAG_W-1:0]  magnitude;
	logic                       last_of_frame;

	modport source (output valid, output edge_flag, output magnitude, output last_of_frame,
		input ready);
	modport sink (input valid, input edge_flag, input magnitude, input last_of_frame,
		output ready);
endinterface

`default_nettype wire

// File: rtl/pew_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pew_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/pew_kernel.sv
// Prewitt horizontal and vertical sums, magnitude and threshold compare.
`default_nettype none

module pew_kernel (
	input  wire pew_pkg::win_t              win,
	input  wire logic [pew_pkg::THR_W-1:0]  thresh,
	output      logic [pew_pkg::MAG_W-1:0]  mag,
	output      logic                       edge_flag
);
	import pew_pkg::*;

	logic [SUM_W-1:0] left, right, upper, lower;
	logic [SUM_W-1:0] ax, ay;

	always_comb begin
		left  = SUM_W'(win.tl) + SUM_W'(win.ml) + SUM_W'(win.bl);
		right = SUM_W'(win.tr) + SUM_W'(win.mr) + SUM_W'(win.br);
		upper = SUM_W'(win.tl) + SUM_W'(win.tc) + SUM_W'(win.tr);
		lower = SUM_W'(win.bl) + SUM_W'(win.bc) + SUM_W'(win.br);
		ax = (right >= left) ? right - left : left - right;
		ay = (lower >= upper) ? lower - upper : upper - lower;
		mag = MAG_W'(ax) + MAG_W'(ay);
		edge_flag = mag > MAG_W'(thresh);
	end

endmodule

`default_nettype wire

// File: rtl/prewitt_edge_threshold_core.sv
// Top level of the streaming Prewitt edge detector with threshold.
//
//   channel   dir   handshake            payload
//   pixels    in    valid/ready          pixel[7:0], frame_start
//   results   out   valid/ready          edge_flag, magnitude[10:0], last_of_frame
//   apb       in    psel/penable/pready  paddr[3:0], pwdata/prdata[31:0]
//
// One pixel beat per cycle unless the output stalls.
// The line store read is issued at the pixel beat; stage 1 forms the window and
// the sums, the output register holds the result.
// A stalled output holds stage 1 and then the pixel channel.
// Reset clears counters, window and valid flags; line stores are not cleared.
`default_nettype none

module prewitt_edge_threshold_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pew_pix_if.sink                          pixels,
	pew_res_if.source                        results,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pew_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pew_pkg::APB_DW-1:0]  pwdata,
	output      logic [pew_pkg::APB_DW-1:0]  prdata,
	output      logic                        pready
);
	import pew_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [THR_W-1:0] thresh_q;
	reg_idx_t         reg_sel;
	logic             cfg_wr;

	logic [CNT_W-1:0] used_w;
	logic [HGT_W-1:0] used_h;

	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;

	logic             acc;
	logic [COL_W-1:0] c0, col_d;
	logic [HGT_W-1:0] r0, row_d;
	logic [HGT_W:0]   r1;
	logic [CNT_W-1:0] col_inc;
	logic [HGT_W:0]   row_inc;
	logic             byp_d;
	logic             last_d;

	logic             s1_valid;
	logic             s1_adv;
	logic [PIX_W-1:0] pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic [HGT_W-1:0] row_s1;
	logic             last_s1;
	logic             byp_s1;
	logic [PIX_W-1:0] byp_a_s1, byp_b_s1;
	logic [PIX_W-1:0] ram_a_rd, ram_b_rd;
	logic [PIX_W-1:0] top, mid;
	logic             inner_s1;

	logic [PIX_W-1:0] win_q [6];
	win_t             win;
	logic [MAG_W-1:0] mag;
	logic             edge_d;

	logic             res_valid_q;
	logic             res_edge_q;
	logic [MAG_W-1:0] res_mag_q;
	logic             res_last_q;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HGT_W-1:0];
				REG_THRESH: thresh_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_THRESH: prdata = APB_DW'(thresh_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		used_w = CNT_W'(width_q);
		if (used_w < MIN_DIM) begin
			used_w = MIN_DIM;
		end else if (used_w > MAX_DIM) begin
			used_w = MAX_DIM;
		end
		used_h = (height_q < HGT_W'(3)) ? HGT_W'(3) : height_q;
	end

	// Position of the incoming beat and the next position
	assign s1_adv       = s1_valid && (!res_valid_q || results.ready);
	assign pixels.ready = !s1_valid || s1_adv;
	assign acc          = pixels.valid && pixels.ready;

	always_comb begin
		c0 = pixels.frame_start ? '0 : col_q;
		r0 = pixels.frame_start ? '0 : row_q;
		if (CNT_W'(c0) >= used_w) begin
			col_d = '0;
			r1    = (HGT_W + 1)'(r0) + 1'b1;
		end else begin
			col_d = c0;
			r1    = (HGT_W + 1)'(r0);
		end
		row_d   = (r1 >= (HGT_W + 1)'(used_h)) ? '0 : r1[HGT_W-1:0];
		col_inc = CNT_W'(col_d) + 1'b1;
		row_inc = (HGT_W + 1)'(row_d) + 1'b1;
		last_d  = (row_inc == (HGT_W + 1)'(used_h)) && (col_inc == used_w);
		byp_d   = s1_valid && (col_s1 == col_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_inc >= used_w) begin
				col_q <= '0;
				row_q <= (row_inc >= (HGT_W + 1)'(used_h)) ? '0 : row_inc[HGT_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= row_d;
			end
		end
	end

	// Line stores: a holds the previous line, b the one before
	pew_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (acc),
		.raddr (col_d),
		.rdata (ram_a_rd)
	);

	pew_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (col_s1),
		.wdata (mid),
		.re    (acc),
		.raddr (col_d),
		.rdata (ram_b_rd)
	);

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pixel_s1 <= pixels.pixel;
			col_s1   <= col_d;
			row_s1   <= row_d;
			last_s1  <= last_d;
			byp_s1   <= byp_d;
			byp_a_s1 <= pixel_s1;
			byp_b_s1 <= mid;
		end
	end

	assign top      = byp_s1 ? byp_b_s1 : ram_b_rd;
	assign mid      = byp_s1 ? byp_a_s1 : ram_a_rd;
	assign inner_s1 = (row_s1 >= HGT_W'(2)) && (col_s1 >= COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pixel_s1;
		end
	end

	always_comb begin
		win.tl = win_q[0];
		win.ml = win_q[1];
		win.bl = win_q[2];
		win.tc = win_q[3];
		win.bc = win_q[5];
		win.tr = top;
		win.mr = mid;
		win.br = pixel_s1;
	end

	pew_kernel u_kernel (
		.win       (win),
		.thresh    (thresh_q),
		.mag       (mag),
		.edge_flag (edge_d)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= inner_s1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && inner_s1) begin
			res_edge_q <= edge_d;
			res_mag_q  <= mag;
			res_last_q <= last_s1;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.edge_flag     = res_edge_q;
	assign results.magnitude     = res_mag_q;
	assign results.last_of_frame = res_last_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> s1_valid && res_valid_q && !results.ready)
		else $error("pixel channel stalled without a blocked result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(col_s1) && $stable(pixel_s1))
		else $error("stage 1 lost its beat while held");

	a_acc_fills: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid)
		else $error("accepted beat did not reach stage 1");

	a_byp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		acc && byp_d |-> s1_adv)
		else $error("bypass taken without a line store write");

endmodule

`default_nettype wire
